[design/dphr_pkg.sv]
package dphr_pkg;

	// Component width of a prescaled momentum vector, limit 2^24 included.
	localparam int PW = 26;
	localparam int PRE_LIM = 24;
	// Normal vectors and the squeezed dot and cross terms, limit 2^30 included.
	localparam int NRM_LIM = 30;
	localparam int NW = 32;
	localparam int PRODW = 2 * PW;
	// Wide datapath for products, the root and the rotator.
	localparam int WW = 64;
	localparam int SQ_STEPS = 31;
	localparam int ITERS = 40;
	localparam int CORDIC_SCALE = 28;
	localparam int ZQ = 40;
	localparam int ZW = 48;
	localparam int ANGLE_BITS = 19;
	localparam int OUT_DW = 24;

	typedef struct packed {
		logic vld;
		logic neg;
		logic degen;
	} ctl_t;

	function automatic logic [WW-1:0] mag64(logic signed [WW-1:0] v);
		return v[WW-1] ? WW'(-v) : WW'(v);
	endfunction

	// Least right shift that brings a magnitude of m into [0, 2^lim].
	function automatic logic [5:0] squeeze_shift(logic [WW-1:0] m, int lim);
		logic [5:0] s;
		s = '0;
		for (int k = 0; k < 63; k++) begin
			if ((lim + k < 63) && (m > (64'd1 << (lim + k))))
				s = s + 6'd1;
		end
		return s;
	endfunction

	// Quotient by shift and subtract; it is only evaluated while the angle
	// table constants are elaborated.
	function automatic longint unsigned udiv64(longint unsigned a, longint unsigned d);
		longint unsigned qt;
		longint unsigned rm;
		qt = '0;
		rm = '0;
		for (int b = 63; b >= 0; b--) begin
			rm = {rm[62:0], a[b]};
			if (rm >= d) begin
				rm = rm - d;
				qt[b] = 1'b1;
			end
		end
		return qt;
	endfunction

	// Alternating series of atan(1/n) in Q62, rounded half up to Q40.
	function automatic longint unsigned atan_sum(longint unsigned p_init, int shift2,
		bit by_three);
		longint unsigned p;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned t;
		p = p_init;
		pos = 0;
		neg = 0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				t = udiv64(p, 64'(2 * k + 1));
				if ((k & 1) == 1)
					neg = neg + t;
				else
					pos = pos + t;
				p = by_three ? udiv64(p, 64'd9) : (p >> shift2);
			end
		end
		return ((pos - neg) + (64'd1 << 21)) >> 22;
	endfunction

	// Rotation angle of CORDIC step i in Q40; step zero is atan(1/2) + atan(1/3).
	function automatic longint unsigned atan_q40(int i);
		if (i == 0)
			return atan_sum(64'd1 << 61, 2, 1'b0) + atan_sum(64'h1555555555555555, 0, 1'b1);
		return atan_sum(64'd1 << (62 - i), 2 * i, 1'b0);
	endfunction

endpackage

[design/dphr_isqrt.sv]
module dphr_isqrt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  dphr_pkg::ctl_t                        ctl_in,
	input  logic signed [dphr_pkg::NW-1:0]        x_in,
	input  logic [dphr_pkg::WW-1:0]               v_in,
	output dphr_pkg::ctl_t                        ctl_out,
	output logic signed [dphr_pkg::NW-1:0]        x_out,
	output logic [dphr_pkg::NW-1:0]               y_out
);

	localparam int STEPS = dphr_pkg::SQ_STEPS;

	logic [dphr_pkg::WW-1:0]        v_s [1:STEPS];
	logic [dphr_pkg::WW-1:0]        r_s [1:STEPS];
	logic signed [dphr_pkg::NW-1:0] x_s [1:STEPS];
	dphr_pkg::ctl_t                 ctl_s [1:STEPS];

	// One result bit per stage, from bit 2^60 of the radicand down to 2^0.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [dphr_pkg::WW-1:0] BIT = 64'd1 << (60 - 2 * k);
		logic [dphr_pkg::WW-1:0]        v_i;
		logic [dphr_pkg::WW-1:0]        r_i;
		logic signed [dphr_pkg::NW-1:0] x_i;
		dphr_pkg::ctl_t                 c_i;
		logic [dphr_pkg::WW-1:0]        trial;

		if (k == 0) begin : g_first
			assign v_i = v_in;
			assign r_i = '0;
			assign x_i = x_in;
			assign c_i = ctl_in;
		end else begin : g_next
			assign v_i = v_s[k];
			assign r_i = r_s[k];
			assign x_i = x_s[k];
			assign c_i = ctl_s[k];
		end

		assign trial = r_i + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1] <= x_i;
				if (v_i >= trial) begin
					v_s[k+1] <= v_i - trial;
					r_s[k+1] <= (r_i >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_i;
					r_s[k+1] <= r_i >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= c_i;
			end
		end
	end

	assign ctl_out = ctl_s[STEPS];
	assign x_out   = x_s[STEPS];
	assign y_out   = r_s[STEPS][dphr_pkg::NW-1:0];

endmodule

[design/dphr_cordic.sv]
module dphr_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  dphr_pkg::ctl_t                        ctl_in,
	input  logic signed [dphr_pkg::NW-1:0]        x_in,
	input  logic [dphr_pkg::NW-1:0]               y_in,
	output dphr_pkg::ctl_t                        ctl_out,
	output logic                                  base_out,
	output logic signed [dphr_pkg::ZW-1:0]        z_out
);

	localparam int N = dphr_pkg::ITERS;

	logic signed [dphr_pkg::WW-1:0] x_s [0:N];
	logic signed [dphr_pkg::WW-1:0] y_s [0:N];
	logic signed [dphr_pkg::ZW-1:0] z_s [0:N];
	logic                           b_s [0:N];
	dphr_pkg::ctl_t                 ctl_s [0:N];

	logic signed [dphr_pkg::WW-1:0] x_ext;
	logic signed [dphr_pkg::WW-1:0] y_ext;

	assign x_ext = dphr_pkg::WW'(x_in);
	assign y_ext = $signed(dphr_pkg::WW'(y_in));

	// A negative dot product is turned by a quarter turn first, so the
	// rotator only sees the right half plane.
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				x_s[0] <= y_ext <<< dphr_pkg::CORDIC_SCALE;
				y_s[0] <= (-x_ext) <<< dphr_pkg::CORDIC_SCALE;
				b_s[0] <= 1'b1;
			end else begin
				x_s[0] <= x_ext <<< dphr_pkg::CORDIC_SCALE;
				y_s[0] <= y_ext <<< dphr_pkg::CORDIC_SCALE;
				b_s[0] <= 1'b0;
			end
			z_s[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [dphr_pkg::ZW-1:0] AT = dphr_pkg::ZW'(dphr_pkg::atan_q40(i));

		always_ff @(posedge clk) begin
			if (en) begin
				b_s[i+1] <= b_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end
	end

	assign ctl_out  = ctl_s[N];
	assign base_out = b_s[N];
	assign z_out    = z_s[N];

endmodule

[design/dihadron_phi_r_angle.sv]
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: q, l, h1, h2 components
// m_*       out        m_tvalid/m_tready  m_tdata: angle; m_tuser: status
//
// One item enters per cycle unless the output stalls; it passes 11 stages of
// vector arithmetic, 31 stages of square root (one result bit each) and 41 stages
// of rotation (a quarter-turn stage, then one CORDIC step each), then rounding and
// the output register.
// Reset clears the valid and control bits only; no clearing pass is needed.
// The whole pipeline holds while the output item waits, so nothing is lost.
module dihadron_phi_r_angle #(
	parameter int IN_WIDTH = 24,
	parameter int ANGLE_FRAC = 16,
	localparam int S_DW = ((12 * IN_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// q_x, q_y, q_z, l_x, l_y, l_z, h1_x, h1_y, h1_z, h2_x, h2_y, h2_z
	input  logic [S_DW-1:0]               s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// angle
	output logic [dphr_pkg::OUT_DW-1:0]   m_tdata,
	// status
	output logic                          m_tuser
);

	localparam int VW = IN_WIDTH + 1;
	localparam int PW = dphr_pkg::PW;
	localparam int PRODW = dphr_pkg::PRODW;
	localparam int NW = dphr_pkg::NW;
	localparam int WW = dphr_pkg::WW;
	localparam int ZW = dphr_pkg::ZW;
	localparam int CHW = PRODW - 24;
	localparam int DHW = PW + CHW + 2;
	localparam int DLW = PW + 25 + 2;
	localparam int DTW = DHW + 26;
	localparam int SHR = dphr_pkg::ZQ - ANGLE_FRAC;
	localparam logic signed [ZW-1:0] A0 = ZW'(dphr_pkg::atan_q40(0));
	localparam logic signed [ZW-1:0] HALF_PI2 = A0 <<< 1;
	localparam logic signed [ZW-1:0] PI_Q = A0 <<< 2;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SHR - 1);
	// Cross product operand indices: c[j] = a[IA[2j]] b[IB[2j]] - a[IA[2j+1]] b[IB[2j+1]].
	localparam int IA [6] = '{1, 2, 2, 0, 0, 1};
	localparam int IB [6] = '{2, 1, 0, 2, 1, 0};
	// Vectors: 0 is q, 1 is l, 2 is D = h1 - h2. Crosses: l x D, q x l, q x D.
	localparam int XA [3] = '{1, 0, 0};
	localparam int XB [3] = '{2, 1, 2};

	logic adv;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic signed [IN_WIDTH-1:0] fld [12];

	for (genvar f = 0; f < 12; f++) begin : g_fld
		assign fld[f] = s_tdata[f*IN_WIDTH +: IN_WIDTH];
	end

	logic vld_s [1:6];

	// Stage 1: widen the fields and form D.
	logic signed [VW-1:0] raw_s1 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				raw_s1[0][c] <= VW'(fld[c]);
				raw_s1[1][c] <= VW'(fld[3+c]);
				raw_s1[2][c] <= VW'(fld[6+c]) - VW'(fld[9+c]);
			end
		end
	end

	// Stage 2: each vector alone is floor-shifted into [-2^24, 2^24]. q and l only
	// shift when the inputs are wider than 25 bits; D = h1 - h2 can need a shift
	// of one already at 25 bits.
	logic [WW-1:0] pm [3];
	logic [5:0]    psh [3];
	logic signed [PW-1:0] pre_s2 [3][3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			pm[v] = '0;
			for (int c = 0; c < 3; c++) begin
				if (dphr_pkg::mag64(WW'(raw_s1[v][c])) > pm[v])
					pm[v] = dphr_pkg::mag64(WW'(raw_s1[v][c]));
			end
			psh[v] = dphr_pkg::squeeze_shift(pm[v], dphr_pkg::PRE_LIM);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 3; v++)
				for (int c = 0; c < 3; c++)
					pre_s2[v][c] <= PW'($signed(WW'(raw_s1[v][c])) >>> psh[v]);
		end
	end

	// Stage 3: the eighteen partial products of the three cross products.
	logic signed [PRODW-1:0] prod_s3 [3][6];
	logic signed [PW-1:0]    q_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int x = 0; x < 3; x++)
				for (int j = 0; j < 6; j++)
					prod_s3[x][j] <= pre_s2[XA[x]][IA[j]] * pre_s2[XB[x]][IB[j]];
			q_s3 <= pre_s2[0];
		end
	end

	// Stage 4: l x D, n1 = q x l and n2 = q x D, all exact.
	logic signed [PRODW-1:0] crs_s4 [3][3];
	logic signed [PW-1:0]    q_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int x = 0; x < 3; x++)
				for (int c = 0; c < 3; c++)
					crs_s4[x][c] <= prod_s3[x][2*c] - prod_s3[x][2*c+1];
			q_s4 <= q_s3;
		end
	end

	// Stage 5: det(q, l, D) = q . (l x D) is split into high and low halves of
	// l x D to keep the multipliers narrow; the normals are squeezed to 2^30.
	logic signed [CHW-1:0] ch [3];
	logic signed [24:0]    cl [3];
	logic [WW-1:0]         nm [2];
	logic [5:0]            nsh [2];
	logic signed [DHW-1:0] dh_s5 [3];
	logic signed [DLW-1:0] dl_s5 [3];
	logic signed [NW-1:0]  nrm_s5 [2][3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ch[c] = CHW'(crs_s4[0][c] >>> 24);
			cl[c] = {1'b0, crs_s4[0][c][23:0]};
		end
		for (int v = 0; v < 2; v++) begin
			nm[v] = '0;
			for (int c = 0; c < 3; c++) begin
				if (dphr_pkg::mag64(WW'(crs_s4[v+1][c])) > nm[v])
					nm[v] = dphr_pkg::mag64(WW'(crs_s4[v+1][c]));
			end
			nsh[v] = dphr_pkg::squeeze_shift(nm[v], dphr_pkg::NRM_LIM);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				dh_s5[c] <= q_s4[c] * ch[c];
				dl_s5[c] <= q_s4[c] * cl[c];
			end
			for (int v = 0; v < 2; v++)
				for (int c = 0; c < 3; c++)
					nrm_s5[v][c] <= NW'($signed(WW'(crs_s4[v+1][c])) >>> nsh[v]);
		end
	end

	// Stage 6: sums of the determinant halves; the dot product and cross
	// product of the normals as nine partial products.
	logic signed [DHW-1:0] hi_s6;
	logic signed [DLW-1:0] lo_s6;
	logic signed [WW-1:0]  np_s6 [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s6 <= dh_s5[0] + dh_s5[1] + dh_s5[2];
			lo_s6 <= dl_s5[0] + dl_s5[1] + dl_s5[2];
			for (int c = 0; c < 3; c++)
				np_s6[c] <= nrm_s5[0][c] * nrm_s5[1][c];
			for (int j = 0; j < 6; j++)
				np_s6[3+j] <= nrm_s5[0][IA[j]] * nrm_s5[1][IB[j]];
		end
	end

	// Stage 7: the sign of the determinant decides the sign of the angle; a
	// zero determinant marks the item degenerate.
	logic signed [DTW-1:0] det;
	logic signed [WW-1:0]  w_s7 [4];
	dphr_pkg::ctl_t        ctl_s7;

	assign det = (DTW'(hi_s6) <<< 24) + DTW'(lo_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s7[0] <= np_s6[0] + np_s6[1] + np_s6[2];
			for (int c = 0; c < 3; c++)
				w_s7[c+1] <= np_s6[3+2*c] - np_s6[4+2*c];
		end
	end

	// Stage 8: largest magnitude of the dot product and the cross product.
	logic [WW-1:0]        wm;
	logic [WW-1:0]        wm_s8;
	logic signed [WW-1:0] w_s8 [4];
	dphr_pkg::ctl_t       ctl_s8;

	always_comb begin
		wm = '0;
		for (int k = 0; k < 4; k++) begin
			if (dphr_pkg::mag64(w_s7[k]) > wm)
				wm = dphr_pkg::mag64(w_s7[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wm_s8 <= wm;
			w_s8  <= w_s7;
		end
	end

	// Stage 9: one common floor shift into [-2^30, 2^30].
	logic [5:0]           wsh;
	logic signed [NW-1:0] w_s9 [4];
	dphr_pkg::ctl_t       ctl_s9;

	assign wsh = dphr_pkg::squeeze_shift(wm_s8, dphr_pkg::NRM_LIM);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++)
				w_s9[k] <= NW'(w_s8[k] >>> wsh);
		end
	end

	// Stage 10: squares of the cross product components.
	logic [WW-1:0]        sq_s10 [3];
	logic signed [NW-1:0] x_s10;
	dphr_pkg::ctl_t       ctl_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++)
				sq_s10[c] <= WW'(w_s9[c+1] * w_s9[c+1]);
			x_s10 <= w_s9[0];
		end
	end

	// Stage 11: squared length of n1 x n2, the radicand for the root.
	logic [WW-1:0]        ss_s11;
	logic signed [NW-1:0] x_s11;
	dphr_pkg::ctl_t       ctl_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s11 <= sq_s10[0] + sq_s10[1] + sq_s10[2];
			x_s11  <= x_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 6; k++)
				vld_s[k] <= 1'b0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
		end else if (adv) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= 6; k++)
				vld_s[k] <= vld_s[k-1];
			ctl_s7.vld   <= vld_s[6];
			ctl_s7.neg   <= det < 0;
			ctl_s7.degen <= det == 0;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
		end
	end

	// Root of the squared cross length, one bit per stage.
	dphr_pkg::ctl_t       sq_ctl;
	logic signed [NW-1:0] sq_x;
	logic [NW-1:0]        sq_y;

	dphr_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_in  (ctl_s11),
		.x_in    (x_s11),
		.v_in    (ss_s11),
		.ctl_out (sq_ctl),
		.x_out   (sq_x),
		.y_out   (sq_y)
	);

	// atan2(y, x) by vectoring rotation, one step per stage.
	dphr_pkg::ctl_t       cr_ctl;
	logic                 cr_base;
	logic signed [ZW-1:0] cr_z;

	dphr_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_in   (sq_ctl),
		.x_in     (sq_x),
		.y_in     (sq_y),
		.ctl_out  (cr_ctl),
		.base_out (cr_base),
		.z_out    (cr_z)
	);

	// Final stage one: add the quarter-turn offset and clamp to [0, pi].
	logic signed [ZW-1:0] a_sum;
	logic signed [ZW-1:0] a_f1;
	dphr_pkg::ctl_t       ctl_f1;

	assign a_sum = cr_z + (cr_base ? HALF_PI2 : ZW'(0));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (a_sum < 0)
				a_f1 <= '0;
			else if (a_sum > PI_Q)
				a_f1 <= PI_Q;
			else
				a_f1 <= a_sum;
		end
	end

	// Output register: round half up to the output format, apply the sign and give a zero angle for a degenerate item.
	logic signed [ZW-1:0]                 r_rnd;
	logic signed [ZW-1:0]                 r_sgn;
	logic [dphr_pkg::ANGLE_BITS-1:0]      angle_q;
	logic                                 status_q;
	logic                                 tvalid_q;

	assign r_rnd = (a_f1 + HALF) >>> SHR;
	assign r_sgn = ctl_f1.neg ? -r_rnd : r_rnd;

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q  <= ctl_f1.degen ? '0 : r_sgn[dphr_pkg::ANGLE_BITS-1:0];
			status_q <= ctl_f1.degen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_f1   <= '0;
			tvalid_q <= 1'b0;
		end else if (adv) begin
			ctl_f1   <= cr_ctl;
			tvalid_q <= ctl_f1.vld;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {(dphr_pkg::OUT_DW - dphr_pkg::ANGLE_BITS)'(0), angle_q};
	assign m_tuser  = status_q;

endmodule

[design/dphr_checker.sv]
module dphr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dphr_pkg::OUT_DW-1:0]   m_tdata,
	input logic                          m_tuser
);

	// A result that waits is held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// A degenerate item always reports a zero angle.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate item with nonzero angle");

	// The padding above the angle stays clear.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[dphr_pkg::OUT_DW-1:dphr_pkg::ANGLE_BITS] == '0)
		else $error("padding bits set");

	// With no result waiting the input side never stalls.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind dihadron_phi_r_angle dphr_checker u_dphr_checker (.*);
